FILE: rtl/kst_pkg.sv
`default_nettype none

package kst_pkg;

  localparam int KEY_COUNT   = 127;
  localparam int KEY_CODE_W  = 7;
  localparam int CHAR_W      = 8;
  localparam int QUEUE_DEPTH = 64;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int CMD_DEPTH   = 2;
  localparam int OUT_DEPTH   = 4;

  localparam logic [KEY_CODE_W-1:0] CAPS_CODE    = 7'd126;
  localparam logic [KEY_CODE_W-1:0] LETTER_FIRST = 7'd1;
  localparam logic [KEY_CODE_W-1:0] LETTER_LAST  = 7'd26;

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_TAKE   = 1'b1;

  typedef enum logic {
    CMD_PUSH,
    CMD_TAKE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [CHAR_W-1:0] ch;
  } cmd_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              none;
  } result_t;

  // US layout, unshifted
  function automatic logic [CHAR_W-1:0] plain_char(input logic [KEY_CODE_W-1:0] code);
    logic [CHAR_W-1:0] c;
    case (code) inside
      [7'd1:7'd26]:  c = 8'h60 + {1'b0, code};
      [7'd27:7'd36]: c = 8'h15 + {1'b0, code};
      7'd60:         c = 8'h60;
      7'd61:         c = 8'h2D;
      7'd62:         c = 8'h3D;
      7'd63:         c = 8'h08;
      7'd64:         c = 8'h09;
      7'd65:         c = 8'h5B;
      7'd66:         c = 8'h5D;
      7'd67:         c = 8'h0A;
      7'd69:         c = 8'h27;
      7'd70:         c = 8'h5C;
      7'd72:         c = 8'h2C;
      7'd73:         c = 8'h2E;
      7'd74:         c = 8'h2F;
      7'd75:         c = 8'h20;
      7'd105:        c = 8'h3B;
      default:       c = 8'h00;
    endcase
    return c;
  endfunction

  // US layout, shifted
  function automatic logic [CHAR_W-1:0] upper_char(input logic [KEY_CODE_W-1:0] code);
    logic [CHAR_W-1:0] c;
    case (code) inside
      [7'd1:7'd26]: c = 8'h40 + {1'b0, code};
      7'd27:        c = 8'h29;
      7'd28:        c = 8'h21;
      7'd29:        c = 8'h40;
      7'd30:        c = 8'h23;
      7'd31:        c = 8'h24;
      7'd32:        c = 8'h25;
      7'd33:        c = 8'h5E;
      7'd34:        c = 8'h26;
      7'd35:        c = 8'h2A;
      7'd36:        c = 8'h28;
      7'd60:        c = 8'h7E;
      7'd61:        c = 8'h5F;
      7'd62:        c = 8'h2B;
      7'd63:        c = 8'h08;
      7'd64:        c = 8'h09;
      7'd65:        c = 8'h7B;
      7'd66:        c = 8'h7D;
      7'd67:        c = 8'h0A;
      7'd69:        c = 8'h22;
      7'd70:        c = 8'h7C;
      7'd72:        c = 8'h3C;
      7'd73:        c = 8'h3E;
      7'd74:        c = 8'h3F;
      7'd75:        c = 8'h20;
      7'd105:       c = 8'h3A;
      default:      c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/kst_ram.sv
`default_nettype none

module kst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/kst_front.sv
`default_nettype none

module kst_front (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             accept,
  input  wire logic                             func,
  input  wire logic                             scan_first,
  input  wire logic                             shift_held,
  input  wire logic                             caps_key_down,
  input  wire logic [kst_pkg::KEY_CODE_W-1:0]   key_code,
  input  wire logic                             key_down,
  output logic                                  cmd_valid,
  output kst_pkg::cmd_t                         cmd
);

  logic [kst_pkg::KEY_COUNT-1:0] level;
  logic                          caps;

  logic                          is_sample;
  logic                          known;
  logic                          prev;
  logic                          toggle;
  logic                          caps_eff;
  logic                          is_letter;
  logic                          rise;
  logic [kst_pkg::CHAR_W-1:0]    plain_ch;
  logic [kst_pkg::CHAR_W-1:0]    upper_ch;
  logic [kst_pkg::CHAR_W-1:0]    raw_ch;

  always_comb begin
    is_sample = (func == kst_pkg::FUNC_SAMPLE);
    known     = int'(key_code) < kst_pkg::KEY_COUNT;
    prev      = known && level[key_code];
    // caps toggles before this sample is translated
    toggle    = is_sample && scan_first && caps_key_down && !level[kst_pkg::CAPS_CODE];
    caps_eff  = caps ^ toggle;
    is_letter = (key_code >= kst_pkg::LETTER_FIRST) && (key_code <= kst_pkg::LETTER_LAST);
    rise      = known && key_down && !prev;
    plain_ch  = kst_pkg::plain_char(key_code);
    upper_ch  = kst_pkg::upper_char(key_code);
    raw_ch    = shift_held ? upper_ch : plain_ch;

    cmd.kind = is_sample ? kst_pkg::CMD_PUSH : kst_pkg::CMD_TAKE;
    if (caps_eff && is_letter) begin
      cmd.ch = shift_held ? plain_ch : upper_ch;
    end else begin
      cmd.ch = raw_ch;
    end
    cmd_valid = accept && (!is_sample || (rise && (raw_ch != '0)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
      caps  <= 1'b0;
    end else if (accept && is_sample) begin
      caps <= caps_eff;
      if (known) begin
        level[key_code] <= key_down;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/kst_cmd_queue.sv
`default_nettype none

module kst_cmd_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_valid,
  input  wire kst_pkg::cmd_t wr_cmd,
  output logic               full,
  output logic               rd_valid,
  output kst_pkg::cmd_t      rd_cmd,
  input  wire logic          rd_ready
);

  localparam int PTR_W = (kst_pkg::CMD_DEPTH > 1) ? $clog2(kst_pkg::CMD_DEPTH) : 1;
  localparam int CNT_W = $clog2(kst_pkg::CMD_DEPTH + 1);

  kst_pkg::cmd_t    entries [kst_pkg::CMD_DEPTH];
  logic [PTR_W-1:0] wp;
  logic [PTR_W-1:0] rp;
  logic [CNT_W-1:0] count;
  logic             wr_fire;
  logic             rd_fire;

  always_comb begin
    full     = (count == CNT_W'(kst_pkg::CMD_DEPTH));
    rd_valid = (count != '0);
    rd_cmd   = entries[rp];
    wr_fire  = wr_valid && !full;
    rd_fire  = rd_valid && rd_ready;
  end

  always_ff @(posedge clk) begin
    if (wr_fire) begin
      entries[wp] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (wr_fire) begin
        wp <= (wp == PTR_W'(kst_pkg::CMD_DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (rd_fire) begin
        rp <= (rp == PTR_W'(kst_pkg::CMD_DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      case ({wr_fire, rd_fire})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/kst_back.sv
`default_nettype none

module kst_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  input  wire kst_pkg::cmd_t cmd,
  output logic               cmd_ready,
  output logic               empty,
  input  wire logic          pop,
  output kst_pkg::result_t   result
);

  localparam int QW    = kst_pkg::QPTR_W;
  localparam int OPW   = (kst_pkg::OUT_DEPTH > 1) ? $clog2(kst_pkg::OUT_DEPTH) : 1;
  localparam int OCW   = $clog2(kst_pkg::OUT_DEPTH + 1);

  logic [QW-1:0]               wr_ptr;
  logic [QW-1:0]               rd_ptr;
  logic [QW-1:0]               wr_inc;
  logic [QW-1:0]               rd_inc;
  logic                        ring_empty;
  logic                        ring_full;
  logic                        room;
  logic                        fire;
  logic                        take_fire;
  logic                        ram_we;
  logic [kst_pkg::CHAR_W-1:0]  ram_q;

  logic                        rd_valid;
  logic                        rd_none;

  kst_pkg::result_t            out_q [kst_pkg::OUT_DEPTH];
  kst_pkg::result_t            out_entry;
  logic [OPW-1:0]              owp;
  logic [OPW-1:0]              orp;
  logic [OCW-1:0]              out_count;
  logic                        pop_fire;

  always_comb begin
    wr_inc     = (wr_ptr == QW'(kst_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
    rd_inc     = (rd_ptr == QW'(kst_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
    ring_empty = (wr_ptr == rd_ptr);
    ring_full  = (wr_inc == rd_ptr);
    // count the read in flight against the result queue
    room       = ({1'b0, out_count} + {{OCW{1'b0}}, rd_valid}) < (OCW + 1)'(kst_pkg::OUT_DEPTH);
    cmd_ready  = (cmd.kind == kst_pkg::CMD_PUSH) || room;
    fire       = cmd_valid && cmd_ready;
    take_fire  = fire && (cmd.kind == kst_pkg::CMD_TAKE);
    ram_we     = fire && (cmd.kind == kst_pkg::CMD_PUSH) && !ring_full;

    if (rd_none) begin
      out_entry.ch   = '0;
      out_entry.none = 1'b1;
    end else begin
      out_entry.ch   = ram_q;
      out_entry.none = 1'b0;
    end

    empty    = (out_count == '0);
    result   = out_q[orp];
    pop_fire = pop && !empty;
  end

  kst_ram #(
    .WIDTH (kst_pkg::CHAR_W),
    .DEPTH (kst_pkg::QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr),
    .wdata (cmd.ch),
    .raddr (rd_ptr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (take_fire) begin
      rd_none <= ring_empty;
    end
    if (rd_valid) begin
      out_q[owp] <= out_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      rd_valid  <= 1'b0;
      owp       <= '0;
      orp       <= '0;
      out_count <= '0;
    end else begin
      rd_valid <= take_fire;
      if (ram_we) begin
        wr_ptr <= wr_inc;
      end
      if (take_fire && !ring_empty) begin
        rd_ptr <= rd_inc;
      end
      if (rd_valid) begin
        owp <= (owp == OPW'(kst_pkg::OUT_DEPTH - 1)) ? '0 : owp + 1'b1;
      end
      if (pop_fire) begin
        orp <= (orp == OPW'(kst_pkg::OUT_DEPTH - 1)) ? '0 : orp + 1'b1;
      end
      case ({rd_valid, pop_fire})
        2'b10:   out_count <= out_count + 1'b1;
        2'b01:   out_count <= out_count - 1'b1;
        default: out_count <= out_count;
      endcase
    end
  end

  a_result_room: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> (out_count < OCW'(kst_pkg::OUT_DEPTH)))
    else $error("result queue overrun by a read in flight");

  a_take_advances: assert property (@(posedge clk) disable iff (rst)
    (take_fire && !ring_empty) |=> (rd_ptr != $past(rd_ptr)))
    else $error("take from a non-empty ring did not advance the read pointer");

  a_drop_on_full: assert property (@(posedge clk) disable iff (rst)
    (fire && (cmd.kind == kst_pkg::CMD_PUSH) && ring_full) |=> (wr_ptr == $past(wr_ptr)))
    else $error("push into a full ring moved the write pointer");

endmodule

`default_nettype wire

FILE: rtl/key_scan_to_ascii_queue.sv
// Key scan to ASCII character queue.
//
// Input channel (push / full): one transaction per cycle while full is low.
// With func low it is a key sample (scan_first, shift_held, caps_key_down,
// key_code, key_down); a rising key level with a US ASCII character is
// translated and stored in a 64-entry character ring, or dropped when the
// ring already holds 63 characters. With func high the transaction is a take
// and produces exactly one result transaction; key samples produce none.
// Result channel (empty / pop): character and queue_empty of the oldest
// waiting result; queue_empty high means the ring had nothing, character 0.
// A take goes through the command queue, the registered ring read and the
// result queue to the result ports. Throughput: one transaction per cycle per
// side while not held by full or empty, set by the ring's registered read.
// Reset clears the key level bitmap, the caps flag, the ring pointers and all
// queues; no clearing pass is needed, the ring holds no valid data after it.
// When pop stays low, results back up in a four-entry result queue, then
// takes hold in a two-entry command queue and full rises; key samples behind
// a held take wait with it, so ordering is always kept.
`default_nettype none

module key_scan_to_ascii_queue (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           push,
  output logic                                full,
  input  wire logic                           func,
  input  wire logic                           scan_first,
  input  wire logic                           shift_held,
  input  wire logic                           caps_key_down,
  input  wire logic [kst_pkg::KEY_CODE_W-1:0] key_code,
  input  wire logic                           key_down,
  output logic                                empty,
  input  wire logic                           pop,
  output logic      [kst_pkg::CHAR_W-1:0]     character,
  output logic                                queue_empty
);

  logic              accept;
  logic              front_valid;
  kst_pkg::cmd_t     front_cmd;
  logic              back_valid;
  kst_pkg::cmd_t     back_cmd;
  logic              back_ready;
  kst_pkg::result_t  result;

  // front takes a transaction whenever the command queue has a free slot
  assign accept = push && !full;

  kst_front u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .func          (func),
    .scan_first    (scan_first),
    .shift_held    (shift_held),
    .caps_key_down (caps_key_down),
    .key_code      (key_code),
    .key_down      (key_down),
    .cmd_valid     (front_valid),
    .cmd           (front_cmd)
  );

  // decouple classification from ring access
  kst_cmd_queue u_cmd_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (front_valid),
    .wr_cmd   (front_cmd),
    .full     (full),
    .rd_valid (back_valid),
    .rd_cmd   (back_cmd),
    .rd_ready (back_ready)
  );

  kst_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (back_valid),
    .cmd       (back_cmd),
    .cmd_ready (back_ready),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

  assign character   = result.ch;
  assign queue_empty = result.none;

endmodule

`default_nettype wire
